>>> rtl/ssi_pkg.sv
// Shared types and constants for the sphere-sphere intersection pipeline.
package ssi_pkg;

  localparam int unsigned RootBits = 32;
  localparam int unsigned QuotBits = 17;
  localparam logic [63:0] EpsQ32 = 64'd4295;
  localparam logic [16:0] OneQ16 = 17'd65536;

  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [63:0]       rad;
    logic [35:0]       rem;
    logic [31:0]       root;
    logic [2:0][30:0]  mag;
    logic [2:0]        neg;
    logic [30:0]       rsum;
  } sqrt_bus_t;

  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [31:0]       norm;
    logic [2:0][32:0]  rem;
    logic [2:0][16:0]  quot;
    logic [2:0]        feed;
    logic [2:0]        neg;
    logic [30:0]       rsum;
  } div_bus_t;

endpackage

>>> rtl/ssi_sqrt_cell.sv
// One stage of the square root chain: resolves one bit of the root.
module ssi_sqrt_cell (
  input  logic               clk,
  input  logic               rst,
  input  ssi_pkg::sqrt_bus_t in_bus,
  output ssi_pkg::sqrt_bus_t out_bus
);
  import ssi_pkg::*;

  logic [35:0] rem_sh;
  logic [35:0] trial;
  sqrt_bus_t   bus_next;

  always_comb begin
    rem_sh = {in_bus.rem[33:0], in_bus.rad[63:62]};
    trial  = {2'b00, in_bus.root, 2'b01};
    bus_next = in_bus;
    if (rst) begin
      bus_next.valid = 1'b0;
    end
    bus_next.rad = {in_bus.rad[61:0], 2'b00};
    if (rem_sh >= trial) begin
      bus_next.rem  = rem_sh - trial;
      bus_next.root = {in_bus.root[30:0], 1'b1};
    end else begin
      bus_next.rem  = rem_sh;
      bus_next.root = {in_bus.root[30:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    out_bus <= bus_next;
  end

endmodule

>>> rtl/ssi_div_cell.sv
// One stage of the three-lane divider chain: resolves one quotient bit per lane.
module ssi_div_cell (
  input  logic              clk,
  input  logic              rst,
  input  ssi_pkg::div_bus_t in_bus,
  output ssi_pkg::div_bus_t out_bus
);
  import ssi_pkg::*;

  logic [2:0][32:0] rem_sh;
  div_bus_t         bus_next;

  always_comb begin
    bus_next = in_bus;
    if (rst) begin
      bus_next.valid = 1'b0;
    end
    bus_next.feed = 3'b000;
    for (int i = 0; i < 3; i++) begin
      rem_sh[i] = {in_bus.rem[i][31:0], in_bus.feed[i]};
      if (rem_sh[i] >= {1'b0, in_bus.norm}) begin
        bus_next.rem[i]  = rem_sh[i] - {1'b0, in_bus.norm};
        bus_next.quot[i] = {in_bus.quot[i][15:0], 1'b1};
      end else begin
        bus_next.rem[i]  = rem_sh[i];
        bus_next.quot[i] = {in_bus.quot[i][15:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    out_bus <= bus_next;
  end

endmodule

>>> rtl/sphere_sphere_intersect_core.sv
// Top level of the sphere-sphere intersection test pipeline.
//
//   channel   handshake        payload
//   input     start / busy     a_center_*, a_radius, b_center_*, b_radius
//   result    done (strobe)    hit, penetration, axis_x, axis_y, axis_z
//
// One pair is taken every cycle; busy is always low. Each result passes the
// registers for difference, squares and sum (s1, s2 and sq_bus[0]), 32 square
// root cells, 17 divider cells and the output register.
// Reset clears the valid bits of every stage. The receiver cannot stall.
module sphere_sphere_intersect_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] a_center_x,
  input  logic signed [31:0] a_center_y,
  input  logic signed [31:0] a_center_z,
  input  logic [29:0]        a_radius,
  input  logic signed [31:0] b_center_x,
  input  logic signed [31:0] b_center_y,
  input  logic signed [31:0] b_center_z,
  input  logic [29:0]        b_radius,
  output logic               done,
  output logic               hit,
  output logic [30:0]        penetration,
  output logic signed [17:0] axis_x,
  output logic signed [17:0] axis_y,
  output logic signed [17:0] axis_z
);
  import ssi_pkg::*;

  logic signed [2:0][32:0] diff;
  logic [2:0][32:0]        diff_mag;

  logic             s1_valid;
  logic             s1_far;
  logic [2:0][30:0] s1_mag;
  logic [2:0]       s1_neg;
  logic [30:0]      s1_rsum;

  logic             s2_valid;
  logic             s2_far;
  logic [2:0][61:0] s2_sq;
  logic [61:0]      s2_rsq;
  logic [2:0][30:0] s2_mag;
  logic [2:0]       s2_neg;
  logic [30:0]      s2_rsum;

  logic [63:0] dist_sq;
  sqrt_bus_t   sq_bus [RootBits+1];
  div_bus_t    dv_bus [QuotBits+1];
  logic [2:0][16:0] qclamp;

  assign busy = 1'b0;

  always_comb begin
    diff[0] = 33'(b_center_x) - 33'(a_center_x);
    diff[1] = 33'(b_center_y) - 33'(a_center_y);
    diff[2] = 33'(b_center_z) - 33'(a_center_z);
    for (int i = 0; i < 3; i++) begin
      diff_mag[i] = diff[i][32] ? 33'(-diff[i]) : 33'(diff[i]);
    end
  end

  always_ff @(posedge clk) begin
    s1_far  <= (diff_mag[0][32:31] != 2'b00) || (diff_mag[1][32:31] != 2'b00) ||
               (diff_mag[2][32:31] != 2'b00);
    for (int i = 0; i < 3; i++) begin
      s1_mag[i] <= diff_mag[i][30:0];
      s1_neg[i] <= diff[i][32];
    end
    s1_rsum <= 31'(a_radius) + 31'(b_radius);
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s2_sq[i] <= 62'(s1_mag[i]) * 62'(s1_mag[i]);
    end
    s2_rsq  <= 62'(s1_rsum) * 62'(s1_rsum);
    s2_far  <= s1_far;
    s2_mag  <= s1_mag;
    s2_neg  <= s1_neg;
    s2_rsum <= s1_rsum;
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
  end

  assign dist_sq = 64'(s2_sq[0]) + 64'(s2_sq[1]) + 64'(s2_sq[2]);

  always_ff @(posedge clk) begin
    sq_bus[0].hit  <= !s2_far && (dist_sq < 64'(s2_rsq));
    sq_bus[0].rad  <= (dist_sq < EpsQ32) ? EpsQ32 : dist_sq;
    sq_bus[0].rem  <= '0;
    sq_bus[0].root <= '0;
    sq_bus[0].mag  <= s2_mag;
    sq_bus[0].neg  <= s2_neg;
    sq_bus[0].rsum <= s2_rsum;
    if (rst) begin
      sq_bus[0].valid <= 1'b0;
    end else begin
      sq_bus[0].valid <= s2_valid;
    end
  end

  for (genvar k = 0; k < RootBits; k++) begin : g_sqrt
    ssi_sqrt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .in_bus  (sq_bus[k]),
      .out_bus (sq_bus[k+1])
    );
  end

  always_comb begin
    dv_bus[0].valid = sq_bus[RootBits].valid;
    dv_bus[0].hit   = sq_bus[RootBits].hit;
    dv_bus[0].norm  = sq_bus[RootBits].root;
    dv_bus[0].neg   = sq_bus[RootBits].neg;
    dv_bus[0].rsum  = sq_bus[RootBits].rsum;
    for (int i = 0; i < 3; i++) begin
      dv_bus[0].rem[i]  = {3'b000, sq_bus[RootBits].mag[i][30:1]};
      dv_bus[0].quot[i] = '0;
      dv_bus[0].feed[i] = sq_bus[RootBits].mag[i][0];
    end
  end

  for (genvar k = 0; k < QuotBits; k++) begin : g_div
    ssi_div_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .in_bus  (dv_bus[k]),
      .out_bus (dv_bus[k+1])
    );
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qclamp[i] = (dv_bus[QuotBits].quot[i] > OneQ16) ? OneQ16 : dv_bus[QuotBits].quot[i];
    end
  end

  always_ff @(posedge clk) begin
    hit <= dv_bus[QuotBits].hit;
    if (dv_bus[QuotBits].hit) begin
      penetration <= dv_bus[QuotBits].rsum - dv_bus[QuotBits].norm[30:0];
      axis_x <= dv_bus[QuotBits].neg[0] ? -18'(qclamp[0]) : 18'(qclamp[0]);
      axis_y <= dv_bus[QuotBits].neg[1] ? -18'(qclamp[1]) : 18'(qclamp[1]);
      axis_z <= dv_bus[QuotBits].neg[2] ? -18'(qclamp[2]) : 18'(qclamp[2]);
    end else begin
      penetration <= '0;
      axis_x <= '0;
      axis_y <= '0;
      axis_z <= '0;
    end
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_bus[QuotBits].valid;
    end
  end

endmodule
